// ===== hdl/stc_pkg.sv =====
// Shared types, constants and the node combine function for the range-min tree.
package stc_pkg;

	localparam int VAL_W = 31;
	localparam int CNT_W = 11;

	localparam logic [VAL_W-1:0] SENTINEL  = 31'd2000000000;
	localparam logic [VAL_W-1:0] VAL_LIMIT = 31'd1999999999;
	localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

	localparam logic OP_SET   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic [CNT_W-1:0] cnt;
	} node_t;

	localparam node_t NEUTRAL = '{val: SENTINEL, cnt: '0};

	// control that travels with a word down the chain of levels
	typedef struct packed {
		logic valid;
		logic query;
		logic use0;
		logic use1;
	} stc_ctl_t;

	// keep the smaller minimum; equal minima add their counts (saturating)
	function automatic node_t node_merge(node_t a, node_t b);
		node_t          r;
		logic [CNT_W:0] s;
		s = {1'b0, a.cnt} + {1'b0, b.cnt};
		if (b.val < a.val) begin
			r = b;
		end else if (b.val == a.val) begin
			r.val = a.val;
			r.cnt = s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
		end else begin
			r = a;
		end
		return r;
	endfunction

endpackage

// ===== hdl/segment_tree_range_min_with_count_top.sv =====
// Range minimum with count: a chain of one cell per tree level, leaves first, root last.
// Accepts one word per cycle while req_stall is low; results leave via the result register.
// A set takes the same path up the chain and gives no result; a stalled result holds the chain
// only once the next query reaches the root stage.
// After reset a clearing pass steps over the addresses and writes every node to the sentinel
// with count zero; req_stall stays high during that pass.
module segment_tree_range_min_with_count_top #(
	parameter int unsigned LEAVES = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        op,
	input  logic [9:0]                  position,
	input  logic [30:0]                 new_value,
	input  logic [10:0]                 range_left,
	input  logic [10:0]                 range_right,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [30:0]                 min_value,
	output logic [10:0]                 min_count
);
	import stc_pkg::*;

	localparam int LOG = $clog2(LEAVES);
	localparam int LW  = LOG + 1;

	stc_ctl_t        ctl [0:LOG];
	node_t           acc [0:LOG];
	logic [LW-1:0]   lo  [0:LOG];
	logic [LW-1:0]   hi  [0:LOG];
	node_t           rd0 [0:LOG];
	node_t           rd1 [0:LOG];

	logic            adv;
	logic            pos_ok;
	logic [30:0]     val_sat;
	node_t           rsp_node;

	logic            clr_busy_q;
	logic [LOG-1:0]  clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + LOG'(1);
			if (clr_cnt_q == LOG'(LEAVES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign req_stall = clr_busy_q || !adv;
	assign pos_ok    = 32'(position) < LEAVES;
	assign val_sat   = (new_value > VAL_LIMIT) ? VAL_LIMIT : new_value;

	// entry word for the leaf level; a set beyond the leaves enters as a bubble
	always_comb begin
		ctl[0].valid = req_valid && !clr_busy_q && (op == OP_QUERY || pos_ok);
		ctl[0].query = op;
		ctl[0].use0  = 1'b0;
		ctl[0].use1  = 1'b0;
		rd0[0]       = NEUTRAL;
		rd1[0]       = NEUTRAL;
		if (op == OP_QUERY) begin
			acc[0] = NEUTRAL;
			lo[0]  = (32'(range_left) > LEAVES) ? LW'(LEAVES) : LW'(range_left);
			hi[0]  = (32'(range_right) > LEAVES) ? LW'(LEAVES) : LW'(range_right);
		end else begin
			acc[0] = '{val: val_sat, cnt: CNT_W'(1)};
			lo[0]  = LW'(position);
			hi[0]  = '0;
		end
	end

	for (genvar l = 0; l < LOG; l++) begin : g_lvl
		stc_cell #(
			.LEAVES (LEAVES),
			.LEVEL  (l)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.clr_en   (clr_busy_q),
			.clr_addr (clr_cnt_q),
			.in_ctl   (ctl[l]),
			.in_acc   (acc[l]),
			.in_lo    (lo[l]),
			.in_hi    (hi[l]),
			.in_rd0   (rd0[l]),
			.in_rd1   (rd1[l]),
			.out_ctl  (ctl[l+1]),
			.out_acc  (acc[l+1]),
			.out_lo   (lo[l+1]),
			.out_hi   (hi[l+1]),
			.out_rd0  (rd0[l+1]),
			.out_rd1  (rd1[l+1])
		);
	end

	stc_root #(
		.LEAVES (LEAVES)
	) u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctl    (ctl[LOG]),
		.in_acc    (acc[LOG]),
		.in_lo     (lo[LOG]),
		.in_hi     (hi[LOG]),
		.in_rd0    (rd0[LOG]),
		.in_rd1    (rd1[LOG]),
		.adv       (adv),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_node  (rsp_node)
	);

	assign min_value = rsp_node.val;
	assign min_count = rsp_node.cnt;

endmodule

// ===== hdl/stc_cell.sv =====
// One tree level: node memory for the level, combine of the reads from the level below.
module stc_cell #(
	parameter int unsigned LEAVES = 1024,
	parameter int unsigned LEVEL  = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        clr_en,
	input  logic [$clog2(LEAVES)-1:0]   clr_addr,
	input  stc_pkg::stc_ctl_t           in_ctl,
	input  stc_pkg::node_t              in_acc,
	input  logic [$clog2(LEAVES):0]     in_lo,
	input  logic [$clog2(LEAVES):0]     in_hi,
	input  stc_pkg::node_t              in_rd0,
	input  stc_pkg::node_t              in_rd1,
	output stc_pkg::stc_ctl_t           out_ctl,
	output stc_pkg::node_t              out_acc,
	output logic [$clog2(LEAVES):0]     out_lo,
	output logic [$clog2(LEAVES):0]     out_hi,
	output stc_pkg::node_t              out_rd0,
	output stc_pkg::node_t              out_rd1
);
	import stc_pkg::*;

	localparam int          LOG   = $clog2(LEAVES);
	localparam int          LW    = LOG + 1;
	localparam int unsigned DEPTH = LEAVES >> LEVEL;
	localparam int          AW    = LOG - LEVEL;

	node_t           mem [DEPTH];
	node_t           acc_a;
	node_t           acc_n;
	logic            upd;
	logic            in_rng;
	logic            take_lo;
	logic            take_hi;
	logic [LW-1:0]   hi_m1;
	logic [AW-1:0]   ra0;
	logic [AW-1:0]   ra1;
	logic [AW-1:0]   wa;
	logic            clr_hit;

	stc_ctl_t        ctl_q;
	node_t           acc_q;
	logic [LW-1:0]   lo_q;
	logic [LW-1:0]   hi_q;
	node_t           rd0_q;
	node_t           rd1_q;

	always_comb begin
		acc_a = node_merge(in_acc, in_ctl.use0 ? in_rd0 : NEUTRAL);
		acc_n = node_merge(acc_a, in_ctl.use1 ? in_rd1 : NEUTRAL);
	end

	assign upd     = in_ctl.valid && (in_ctl.query == OP_SET);
	assign in_rng  = in_lo < in_hi;
	assign take_lo = in_rng && in_lo[0];
	assign take_hi = in_rng && in_hi[0];
	assign hi_m1   = in_hi - LW'(1);
	assign wa      = in_lo[AW-1:0];
	// a set reads the sibling of the node it writes
	assign ra0     = upd ? (in_lo[AW-1:0] ^ AW'(1)) : in_lo[AW-1:0];
	assign ra1     = hi_m1[AW-1:0];
	assign clr_hit = 32'(clr_addr) < DEPTH;

	always_ff @(posedge clk) begin
		if (clr_en) begin
			if (clr_hit) begin
				mem[clr_addr[AW-1:0]] <= NEUTRAL;
			end
		end else if (adv && upd) begin
			mem[wa] <= acc_n;
		end
		if (adv) begin
			rd0_q <= mem[ra0];
			rd1_q <= mem[ra1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q.valid <= in_ctl.valid;
			ctl_q.query <= in_ctl.query;
			ctl_q.use0  <= upd ? 1'b1 : take_lo;
			ctl_q.use1  <= upd ? 1'b0 : take_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_q <= acc_n;
			if (upd) begin
				lo_q <= in_lo >> 1;
			end else begin
				lo_q <= (in_lo + LW'(take_lo)) >> 1;
			end
			hi_q <= (in_hi - LW'(take_hi)) >> 1;
		end
	end

	assign out_ctl = ctl_q;
	assign out_acc = acc_q;
	assign out_lo  = lo_q;
	assign out_hi  = hi_q;
	assign out_rd0 = rd0_q;
	assign out_rd1 = rd1_q;

endmodule

// ===== hdl/stc_root.sv =====
// Root node, last combine stage and the result register with its stall control.
module stc_root #(
	parameter int unsigned LEAVES = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  stc_pkg::stc_ctl_t           in_ctl,
	input  stc_pkg::node_t              in_acc,
	input  logic [$clog2(LEAVES):0]     in_lo,
	input  logic [$clog2(LEAVES):0]     in_hi,
	input  stc_pkg::node_t              in_rd0,
	input  stc_pkg::node_t              in_rd1,
	output logic                        adv,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output stc_pkg::node_t              rsp_node
);
	import stc_pkg::*;

	node_t  acc_a;
	node_t  acc_n;
	logic   upd;
	logic   load;

	node_t  root_q;
	logic   st_valid_q;
	node_t  st_acc_q;
	logic   st_take_q;
	logic   rsp_valid_q;
	node_t  rsp_q;

	always_comb begin
		acc_a = node_merge(in_acc, in_ctl.use0 ? in_rd0 : NEUTRAL);
		acc_n = node_merge(acc_a, in_ctl.use1 ? in_rd1 : NEUTRAL);
	end

	assign upd  = in_ctl.valid && (in_ctl.query == OP_SET);
	// freeze the chain only when a finished query cannot move into the result register
	assign adv  = !(st_valid_q && rsp_valid_q && rsp_stall);
	assign load = adv && st_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q      <= NEUTRAL;
			st_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				st_valid_q <= in_ctl.valid && (in_ctl.query == OP_QUERY);
				if (upd) begin
					root_q <= acc_n;
				end
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_acc_q  <= acc_n;
			st_take_q <= in_lo < in_hi;
		end
		if (load) begin
			rsp_q <= node_merge(st_acc_q, st_take_q ? root_q : NEUTRAL);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_node  = rsp_q;

endmodule

// ===== hdl/stc_checker.sv =====
// Port-level checks for the range-min tree, bound to the top level.
module stc_checker #(
	parameter int unsigned LEAVES = 1024
) (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [30:0] min_value,
	input logic [10:0] min_count
);
	import stc_pkg::*;

	// registers reset asynchronously, so no result or acceptance may show while reset is held
	a_idle_in_reset: assert property (@(posedge clk)
		!arst_n ##1 !arst_n |-> !rsp_valid && !(req_valid && !req_stall))
		else $error("result or acceptance during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(min_value) && $stable(min_count))
		else $error("stalled result word changed");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((min_count == '0) == (min_value == SENTINEL)))
		else $error("count zero and sentinel minimum disagree");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(min_count) <= LEAVES)
		else $error("count above leaf total");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> req_stall)
		else $error("word accepted before clearing pass");

endmodule

bind segment_tree_range_min_with_count_top stc_checker #(
	.LEAVES (LEAVES)
) u_stc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.min_value (min_value),
	.min_count (min_count)
);

// ===== test/testbench.sv =====
// Testbench for the range-min-with-count segment tree: directed and random words, scored in order.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import stc_pkg::*;

	localparam int LEAVES       = 1024;
	localparam int TW           = $clog2(2*LEAVES);
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic        op;
		logic [9:0]  position;
		logic [30:0] new_value;
		logic [10:0] range_left;
		logic [10:0] range_right;
	} tree_word_t;

	typedef logic [TW:0] tidx_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        req_valid   = 1'b0;
	logic        req_stall;
	logic        op          = OP_SET;
	logic [9:0]  position    = '0;
	logic [30:0] new_value   = '0;
	logic [10:0] range_left  = '0;
	logic [10:0] range_right = '0;
	logic        rsp_valid;
	logic        rsp_stall   = 1'b0;
	logic [30:0] min_value;
	logic [10:0] min_count;

	tree_word_t word_q[$];
	node_t      min_expected[$];
	node_t      tree [2*LEAVES];

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int errors = 0;
	int cycle_cnt = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	segment_tree_range_min_with_count_top #(
		.LEAVES(LEAVES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.op(op),
		.position(position),
		.new_value(new_value),
		.range_left(range_left),
		.range_right(range_right),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.min_value(min_value),
		.min_count(min_count)
	);

	always #5 clk = ~clk;

	// smaller minimum wins; a tie adds counts, saturating at 11 bits
	function automatic node_t min_combine(node_t a, node_t b);
		node_t       r;
		logic [11:0] sum;
		r = a;
		sum = a.cnt + b.cnt;
		if (b.val < a.val) begin
			r = b;
		end else if (b.val == a.val) begin
			r.cnt = (sum > COUNT_MAX) ? COUNT_MAX : sum[10:0];
		end
		return r;
	endfunction

	function automatic void tree_apply(tree_word_t w);
		tidx_t k;
		tidx_t lo;
		tidx_t hi;
		node_t acc_l;
		node_t acc_r;
		if (w.op == OP_SET) begin
			k = tidx_t'(LEAVES) + tidx_t'(w.position);
			tree[k[TW-1:0]].val = (w.new_value >= SENTINEL) ? VAL_LIMIT : w.new_value;
			tree[k[TW-1:0]].cnt = CNT_W'(1);
			for (k = k >> 1; k >= 1; k = k >> 1)
				tree[k[TW-1:0]] = min_combine(tree[{k[TW-2:0], 1'b0}],
					tree[{k[TW-2:0], 1'b1}]);
		end else begin
			lo = (w.range_left > LEAVES) ? tidx_t'(LEAVES) : tidx_t'(w.range_left);
			hi = (w.range_right > LEAVES) ? tidx_t'(LEAVES) : tidx_t'(w.range_right);
			lo = lo + tidx_t'(LEAVES);
			hi = hi + tidx_t'(LEAVES);
			acc_l = NEUTRAL;
			acc_r = NEUTRAL;
			while (lo < hi) begin
				if (lo[0]) begin
					acc_l = min_combine(acc_l, tree[lo[TW-1:0]]);
					lo++;
				end
				if (hi[0]) begin
					hi--;
					acc_r = min_combine(acc_r, tree[hi[TW-1:0]]);
				end
				lo = lo >> 1;
				hi = hi >> 1;
			end
			min_expected.push_back(min_combine(acc_l, acc_r));
		end
	endfunction

	// driver: a stalled word holds; the next word goes out only after acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			op <= OP_SET;
			position <= '0;
			new_value <= '0;
			range_left <= '0;
			range_right <= '0;
		end else begin
			if (req_valid && !req_stall)
				tree_apply(word_q.pop_front());
			if (!req_valid || !req_stall) begin
				if (word_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					req_valid <= 1'b1;
					op <= word_q[0].op;
					position <= word_q[0].position;
					new_value <= word_q[0].new_value;
					range_left <= word_q[0].range_left;
					range_right <= word_q[0].range_right;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (min_expected.size() == 0) begin
					$error("unexpected result word: min_value %0d min_count %0d",
						min_value, min_count);
					errors++;
				end else begin
					if (min_value !== min_expected[0].val) begin
						$error("min_value: expected %0d, got %0d", min_expected[0].val, min_value);
						errors++;
					end
					if (min_count !== min_expected[0].cnt) begin
						$error("min_count: expected %0d, got %0d", min_expected[0].cnt, min_count);
						errors++;
					end
					void'(min_expected.pop_front());
				end
			end
			rsp_stall <= (hold_left != 0) || ($urandom_range(99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic push_set(int unsigned pos, logic [30:0] val);
		tree_word_t w;
		w = {$urandom, $urandom};
		w.op = OP_SET;
		w.position = 10'(pos);
		w.new_value = val;
		word_q.push_back(w);
	endtask

	task automatic push_query(int unsigned lo, int unsigned hi);
		tree_word_t w;
		w = {$urandom, $urandom};
		w.op = OP_QUERY;
		w.range_left = 11'(lo);
		w.range_right = 11'(hi);
		word_q.push_back(w);
	endtask

	// values lean small and positions cluster so that ties and counts above one show up
	function automatic tree_word_t random_word();
		tree_word_t  w;
		int unsigned lo;
		w = {$urandom, $urandom};
		w.op = ($urandom_range(1) != 0) ? OP_QUERY : OP_SET;
		if ($urandom_range(1) != 0)
			w.position = 10'($urandom_range(63));
		case ($urandom_range(9))
			0, 1, 2, 3, 4: w.new_value = 31'($urandom_range(7));
			5, 6, 7:       w.new_value = 31'($urandom_range(VAL_LIMIT));
			8:             w.new_value = 31'($urandom_range(31'h7fffffff, SENTINEL));
			default:       w.new_value = 31'($urandom);
		endcase
		case ($urandom_range(9))
			0, 1, 2: begin
				lo = $urandom_range(63);
				w.range_left = 11'(lo);
				w.range_right = 11'(lo + $urandom_range(24));
			end
			3, 4, 5: begin
				lo = $urandom_range(LEAVES - 1);
				w.range_left = 11'(lo);
				w.range_right = 11'(lo + $urandom_range(16));
			end
			6, 7: begin
				w.range_left = 11'($urandom_range(LEAVES));
				w.range_right = 11'($urandom_range(LEAVES));
			end
			8: begin
				w.range_left = '0;
				w.range_right = 11'(LEAVES);
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic wait_drained();
		do
			@(negedge clk);
		while (word_q.size() != 0 || req_valid || min_expected.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(int n, int tx_pct, int rx_pct, bit with_hold);
		@(negedge clk);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < n; i++)
			word_q.push_back(random_word());
		if (with_hold)
			hold_asks++;
		wait_drained();
	endtask

	initial begin
		tree = '{default: NEUTRAL};
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// empty tree, extremes, saturation, clamping and empty ranges
		push_query(0, LEAVES);
		push_set(0, 0);
		push_set(LEAVES - 1, VAL_LIMIT);
		push_set(5, 31'h7fffffff);
		push_set(6, SENTINEL);
		push_query(0, LEAVES);
		push_query(1, LEAVES);
		push_query(5, 7);
		push_query(7, 7);
		push_query(10, 3);
		push_query(2047, 2047);
		push_query(0, 2047);
		push_query(LEAVES - 1, LEAVES);
		push_query(LEAVES, LEAVES);
		for (int p = 100; p < 104; p++)
			push_set(p, 42);
		push_query(100, 104);
		push_set(0, 50);
		push_query(0, 1);
		push_query(0, LEAVES);
		push_query(2000, 5);
		wait_drained();

		run_phase(180, 0, 0, 1'b1);
		run_phase(170, 87, 0, 1'b0);
		run_phase(170, 0, 87, 1'b0);
		run_phase(180, 37, 37, 1'b0);

		if (min_expected.size() != 0) begin
			$error("%0d expected result words never arrived", min_expected.size());
			errors++;
		end
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/stc_pkg.sv
hdl/stc_cell.sv
hdl/stc_root.sv
hdl/segment_tree_range_min_with_count_top.sv
hdl/stc_checker.sv
test/testbench.sv
